/* design/ufss_pkg.sv */
// Package for the UDP flow session statistics block.
// Holds sizes, status and register codes, payload structs, FSM state and command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ufss_pkg;

    localparam int SESSIONS = 16;
    localparam int IDX_W    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int CNT_W    = $clog2(SESSIONS + 1);
    localparam int ROW_W    = 32 + 16 + 5 * 32;

    localparam logic [31:0] SEQ_END = 32'hffff_ffff;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_OPENED   = 3'd1;
    localparam logic [2:0] ST_CLOSED   = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic REG_ACK_EVERY    = 1'b0;
    localparam logic REG_LOSS_ENABLED = 1'b1;

    typedef struct packed {
        logic [31:0] client_addr;
        logic [15:0] client_port;
        logic [15:0] mode;
        logic [31:0] seq_num;
        logic [15:0] header_size;
        logic [15:0] received_size;
        logic        drop_draw;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        echo;
        logic [31:0] bytes_total;
        logic [31:0] messages_total;
        logic [31:0] messages_missing;
        logic [31:0] last_sequence;
        logic [31:0] largest_sequence;
        logic [31:0] sessions_opened;
    } t_out_item;

    // One session row as held in the table memory.
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] bytes;
        logic [31:0] messages;
        logic [31:0] lost;
        logic [31:0] last_seq;
        logic [31:0] largest_seq;
    } t_row;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_UPDATE,
        S_REPORT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture input item
        logic scan_clr;   // restart scan index
        logic scan_step;  // advance scan index
        logic update;     // write row, update counters
        logic report;     // drive result strobe
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic mismatch;
        logic scan_last;
        logic hit;
    } t_stat;

endpackage
`default_nettype wire

/* design/ufss_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ufss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or read one word per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

/* design/ufss_ctrl.sv */
// Controller for the session statistics block.
// Depends on ufss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ufss_ctrl
    import ufss_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output logic       o_busy,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    // Hold state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load, scan a key a cycle, read row, update, report; mismatch: report.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.mismatch) begin
                    n_state = S_REPORT;
                end else if (i_stat.hit || i_stat.scan_last) begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = S_READ;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_READ: begin
                // Wait out the registered row read.
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_REPORT;
            end
            S_REPORT: begin
                o_cmd.report = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* design/ufss_dp.sv */
// Datapath: key table, row memory, counters and result register.
// Depends on ufss_pkg and ufss_ram.
`timescale 1ns / 1ps
`default_nettype none
module ufss_dp
    import ufss_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire t_cmd      i_cmd,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_index,
    input  wire logic [9:0] i_cfg_data,
    output t_stat          o_stat,
    output logic           o_strobe,
    output t_out_item      o_item
);

    t_in_item          r_item;
    logic [SESSIONS-1:0] r_valid;
    logic [31:0]       r_key_addr [SESSIONS];
    logic [15:0]       r_key_port [SESSIONS];
    logic [CNT_W-1:0]  r_scan;
    logic [IDX_W-1:0]  r_idx;
    logic              r_found;
    logic              r_have_free;
    logic [IDX_W-1:0]  r_free;
    logic [9:0]        r_ack_every;
    logic              r_loss_en;
    logic [9:0]        r_ack_cnt;
    logic [31:0]       r_open_cnt;
    logic              r_strobe;
    t_out_item         r_out;
    logic [2:0]        r_status;
    logic              r_echo;

    logic [IDX_W-1:0]  scan_idx;
    logic              scan_hit;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    t_row              ram_wdata;
    t_row              ram_rdata;
    t_row              row_old;
    t_row              row_new;
    logic              closing;
    logic [9:0]        ack_inc;
    logic              echo_base;

    assign scan_idx = r_scan[IDX_W-1:0];
    assign scan_hit = r_valid[scan_idx] && r_key_addr[scan_idx] == r_item.client_addr
                      && r_key_port[scan_idx] == r_item.client_port;

    assign o_stat.mismatch  = r_item.header_size != r_item.received_size;
    assign o_stat.hit       = scan_hit;
    assign o_stat.scan_last = r_scan == CNT_W'(SESSIONS - 1);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_every <= 10'd1;
            r_loss_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACK_EVERY:    r_ack_every <= i_cfg_data;
                REG_LOSS_ENABLED: r_loss_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Capture item; scan keys, noting a match and the lowest free entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_cmd.scan_clr) begin
            r_scan      <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + CNT_W'(1);
            if (scan_hit) begin
                r_found <= 1'b1;
                r_idx   <= scan_idx;
            end
            if (!r_valid[scan_idx] && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free      <= scan_idx;
            end
        end
    end

    // Row memory: read at chosen entry, written back on update.
    assign ram_addr = r_found ? r_idx : r_free;
    assign closing  = r_item.seq_num == SEQ_END;
    assign row_old  = r_found ? ram_rdata
                    : t_row'{addr: r_item.client_addr, port: r_item.client_port, default: '0};

    always_comb begin
        row_new = row_old;
        if (!closing) begin
            row_new.bytes    = row_old.bytes + 32'(r_item.received_size);
            row_new.messages = row_old.messages + 32'd1;
            row_new.lost     = row_old.lost + r_item.seq_num - row_old.last_seq - 32'd1;
            row_new.last_seq = r_item.seq_num;
            if (row_old.largest_seq < r_item.seq_num) begin
                row_new.largest_seq = r_item.seq_num;
            end
        end
    end

    assign ram_we    = i_cmd.update && (r_found || r_have_free);
    assign ram_wdata = row_new;

    ufss_ram #(.WIDTH(ROW_W), .DEPTH(SESSIONS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign ack_inc   = r_ack_cnt + 10'd1;
    assign echo_base = !(r_loss_en && r_item.drop_draw);

    // Update entry state, counters and build the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_ack_cnt  <= '0;
            r_open_cnt <= '0;
        end else if (i_cmd.update && (r_found || r_have_free)) begin
            if (!r_found) begin
                r_key_addr[r_free] <= r_item.client_addr;
                r_key_port[r_free] <= r_item.client_port;
                r_open_cnt         <= r_open_cnt + 32'd1;
            end
            r_valid[ram_addr] <= !closing;
            if (r_item.mode == 16'd0 && r_ack_every != 10'd0) begin
                r_ack_cnt <= (ack_inc >= r_ack_every) ? 10'd0 : ack_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= '0;
            r_status <= ST_MISMATCH;
            r_echo   <= 1'b0;
        end else if (i_cmd.update) begin
            if (r_found || r_have_free) begin
                r_out.bytes_total      <= row_new.bytes;
                r_out.messages_total   <= row_new.messages;
                r_out.messages_missing <= row_new.lost;
                r_out.last_sequence    <= row_new.last_seq;
                r_out.largest_sequence <= row_new.largest_seq;
                r_status <= closing ? ST_CLOSED : (r_found ? ST_UPDATED : ST_OPENED);
                if (r_item.mode == 16'd0) begin
                    r_echo <= echo_base
                              || (r_ack_every != 10'd0 && ack_inc >= r_ack_every);
                end
            end else begin
                r_status <= ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.report;
        end
    end

    always_comb begin
        o_item                 = r_out;
        o_item.status          = r_status;
        o_item.echo            = r_echo;
        o_item.sessions_opened = r_open_cnt;
    end
    assign o_strobe = r_strobe;

endmodule
`default_nettype wire

/* design/udp_flow_session_stats.sv */
// Top level of the UDP flow session statistics block.
// Depends on ufss_pkg, ufss_ctrl and ufss_dp.
//
// Usage:
//   Packet descriptors enter on i_item, taken at a clock edge where
//   start is high and busy is low. Each descriptor gives exactly one
//   result on o_item, shown for one cycle with o_strobe high. The
//   receiver cannot stall; the result must be taken in that cycle.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 ack_every, 1 loss_enabled) at once; write only while idle.
//   The key scan visits one table entry a cycle and stops at a match
//   or at the last entry; a row read, an update and a report follow.
//   A length mismatch goes from the scan straight to the report.
//   busy drops in the cycle the result is shown, so the next descriptor
//   can be taken at the edge that ends it; a new descriptor is never
//   taken while one is in flight. The scan over the key table sets how
//   long each descriptor takes.
//   Reset (synchronous, active low) empties the session table, clears
//   the ack and open counters and sets ack_every to 1, loss off.
`timescale 1ns / 1ps
`default_nettype none
module udp_flow_session_stats
    import ufss_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_item,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_index,
    input  wire logic [9:0] i_cfg_data,
    output logic           o_strobe,
    output t_out_item      o_item
);

    t_cmd  cmd;
    t_stat stat;

    ufss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    ufss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_item      (o_item)
    );

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for udp_flow_session_stats.
// Directed table then random descriptors, checked against an in-bench session predictor.
// Depends on ufss_pkg and the design files.
`timescale 1ns / 1ps
module testbench;
    import ufss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1650;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   i_item;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [9:0] i_cfg_data;
    logic       o_strobe;
    t_out_item  o_item;

    udp_flow_session_stats u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_strobe(o_strobe), .o_item(o_item)
    );

    // Predictor copy of the session table and registers
    logic        sess_valid [SESSIONS];
    logic [31:0] sess_addr [SESSIONS];
    logic [15:0] sess_port [SESSIONS];
    logic [31:0] sess_bytes [SESSIONS];
    logic [31:0] sess_msgs [SESSIONS];
    logic [31:0] sess_lost [SESSIONS];
    logic [31:0] sess_last [SESSIONS];
    logic [31:0] sess_big [SESSIONS];
    logic [9:0]  ack_count;
    logic [31:0] opened_count;
    logic [9:0]  ack_every_reg;
    logic        loss_on;

    t_out_item   expected_results[$];
    int          errors;
    longint      cycles;
    logic        no_gaps;

    // Key pools so random traffic revisits sessions and fills the table
    logic [31:0] pool_addr [24];
    logic [15:0] pool_port [24];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_item.status), 32'hx);
            end else begin
                want = expected_results.pop_front();
                if (o_item.status !== want.status)
                    report_mismatch("status", 32'(o_item.status), 32'(want.status));
                if (o_item.echo !== want.echo)
                    report_mismatch("echo", 32'(o_item.echo), 32'(want.echo));
                if (o_item.bytes_total !== want.bytes_total)
                    report_mismatch("bytes_total", o_item.bytes_total, want.bytes_total);
                if (o_item.messages_total !== want.messages_total)
                    report_mismatch("messages_total", o_item.messages_total,
                                    want.messages_total);
                if (o_item.messages_missing !== want.messages_missing)
                    report_mismatch("messages_missing", o_item.messages_missing,
                                    want.messages_missing);
                if (o_item.last_sequence !== want.last_sequence)
                    report_mismatch("last_sequence", o_item.last_sequence,
                                    want.last_sequence);
                if (o_item.largest_sequence !== want.largest_sequence)
                    report_mismatch("largest_sequence", o_item.largest_sequence,
                                    want.largest_sequence);
                if (o_item.sessions_opened !== want.sessions_opened)
                    report_mismatch("sessions_opened", o_item.sessions_opened,
                                    want.sessions_opened);
            end
        end
    end

    // Work out the session result for one descriptor and advance the state
    function automatic t_out_item predict_session(input t_in_item it);
        t_out_item r;
        int        slot;
        logic      fresh;
        r = '0;
        slot = -1;
        fresh = 1'b0;
        if (it.header_size != it.received_size) begin
            r.status = ST_MISMATCH;
        end else begin
            for (int i = 0; i < SESSIONS; i++)
                if (slot < 0 && sess_valid[i] && sess_addr[i] == it.client_addr
                    && sess_port[i] == it.client_port)
                    slot = i;
            if (slot < 0) begin
                for (int i = 0; i < SESSIONS; i++)
                    if (slot < 0 && !sess_valid[i]) slot = i;
                if (slot >= 0) begin
                    sess_valid[slot] = 1'b1;
                    sess_addr[slot]  = it.client_addr;
                    sess_port[slot]  = it.client_port;
                    sess_bytes[slot] = '0;
                    sess_msgs[slot]  = '0;
                    sess_lost[slot]  = '0;
                    sess_last[slot]  = '0;
                    sess_big[slot]   = '0;
                    opened_count++;
                    fresh = 1'b1;
                end
            end
            if (slot < 0) begin
                r.status = ST_FULL;
            end else begin
                if (it.seq_num == SEQ_END) begin
                    sess_valid[slot] = 1'b0;
                    r.status = ST_CLOSED;
                end else begin
                    sess_bytes[slot] += 32'(it.received_size);
                    sess_msgs[slot]  += 1;
                    sess_lost[slot]  += it.seq_num - sess_last[slot] - 1;
                    sess_last[slot]  = it.seq_num;
                    if (sess_big[slot] < it.seq_num) sess_big[slot] = it.seq_num;
                    r.status = fresh ? ST_OPENED : ST_UPDATED;
                end
                if (it.mode == 16'd0) begin
                    r.echo = !(loss_on && it.drop_draw);
                    if (ack_every_reg != 0) begin
                        ack_count = ack_count + 1'b1;
                        if (ack_count >= ack_every_reg) begin
                            r.echo = 1'b1;
                            ack_count = '0;
                        end
                    end
                end
                r.bytes_total      = sess_bytes[slot];
                r.messages_total   = sess_msgs[slot];
                r.messages_missing = sess_lost[slot];
                r.last_sequence    = sess_last[slot];
                r.largest_sequence = sess_big[slot];
            end
        end
        r.sessions_opened = opened_count;
        return r;
    endfunction

    // Transfer one descriptor; queue either a typed result or the prediction
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item p;
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        p = predict_session(it);
        if (typed && p !== want) begin
            report_mismatch("typed row vs predictor", 32'(p.status), 32'(want.status));
            expected_results.push_back(want);
        end else begin
            expected_results.push_back(p);
        end
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain, let the block settle, then write a register
    task automatic write_reg(input logic idx, input logic [9:0] val);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SESSIONS + 6) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ACK_EVERY) ack_every_reg = val;
        else loss_on = val[0];
    endtask

    function automatic t_in_item mk(input logic [31:0] a, input logic [15:0] p,
                                    input logic [15:0] m, input logic [31:0] s,
                                    input logic [15:0] h, input logic [15:0] rs,
                                    input logic d);
        t_in_item it;
        it.client_addr = a; it.client_port = p; it.mode = m; it.seq_num = s;
        it.header_size = h; it.received_size = rs; it.drop_draw = d;
        return it;
    endfunction

    function automatic t_out_item res(input logic [2:0] st, input logic e,
                                      input logic [31:0] b, input logic [31:0] n,
                                      input logic [31:0] l, input logic [31:0] ls,
                                      input logic [31:0] bs, input logic [31:0] o);
        t_out_item r;
        r.status = st; r.echo = e; r.bytes_total = b; r.messages_total = n;
        r.messages_missing = l; r.last_sequence = ls; r.largest_sequence = bs;
        r.sessions_opened = o;
        return r;
    endfunction

    typedef struct {
        t_in_item  it;
        logic      typed;
        t_out_item want;
    } t_row_stim;

    t_row_stim directed[$];

    initial begin
        t_in_item it;
        int       k;
        int       burst;
        errors = 0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_ACK_EVERY;
        i_cfg_data = '0;
        for (int i = 0; i < SESSIONS; i++) begin
            sess_valid[i] = 1'b0;
            sess_addr[i] = '0; sess_port[i] = '0; sess_bytes[i] = '0;
            sess_msgs[i] = '0; sess_lost[i] = '0; sess_last[i] = '0; sess_big[i] = '0;
        end
        ack_count = '0;
        opened_count = '0;
        ack_every_reg = 10'd1;
        loss_on = 1'b0;
        for (int i = 0; i < 24; i++) begin
            pool_addr[i] = $urandom;
            pool_port[i] = 16'($urandom);
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: typed where obvious, otherwise left to the predictor
        directed.push_back('{mk(32'h0, 16'h0, 16'h0, 32'h0, 16'h1, 16'h2, 1'b0), 1'b1,
                             res(ST_MISMATCH, 0, 0, 0, 0, 0, 0, 0)});
        directed.push_back('{mk(32'hffffffff, 16'hffff, 16'h0, 32'h1, 16'hffff, 16'hffff,
                                1'b1), 1'b1,
                             res(ST_OPENED, 1, 32'hffff, 1, 0, 1, 1, 1)});
        directed.push_back('{mk(32'hffffffff, 16'hffff, 16'hffff, 32'h5, 16'h10, 16'h10,
                                1'b0), 1'b0, '0});
        directed.push_back('{mk(32'hffffffff, 16'hffff, 16'h0, 32'h3, 16'h0, 16'h0,
                                1'b0), 1'b0, '0});
        directed.push_back('{mk(32'hffffffff, 16'hffff, 16'h0, SEQ_END, 16'h0, 16'h0,
                                1'b0), 1'b0, '0});
        directed.push_back('{mk(32'h12345678, 16'h0, 16'h1, SEQ_END, 16'h4, 16'h4, 1'b0),
                             1'b1, res(ST_CLOSED, 0, 0, 0, 0, 0, 0, 2)});
        directed.push_back('{mk(32'h0, 16'h0, 16'h8000, 32'hfffffffe, 16'h0, 16'h0, 1'b1),
                             1'b0, '0});
        directed.push_back('{mk(32'h0, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 1'b1),
                             1'b0, '0});
        foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].want);

        // Fill the table to force the full case, then close all
        write_reg(REG_LOSS_ENABLED, 1'b1);
        write_reg(REG_ACK_EVERY, 10'd0);
        for (int i = 0; i < SESSIONS + 1; i++)
            send_item(mk(32'hA000_0000 + i, 16'(i), 16'h0, 32'(i), 16'h8, 16'h8,
                         1'(i)), 1'b0, '0);
        for (int i = 0; i < SESSIONS + 1; i++)
            send_item(mk(32'hA000_0000 + i, 16'(i), 16'h0, SEQ_END, 16'h8, 16'h8, 1'b0),
                      1'b0, '0);
        send_item(mk(32'h0, 16'h0, 16'h0, SEQ_END, 16'h0, 16'h0, 1'b0), 1'b0, '0);

        // Random phases across register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(REG_ACK_EVERY, 10'd1000); write_reg(REG_LOSS_ENABLED, 1'b0); end
                1: write_reg(REG_ACK_EVERY, 10'd3);
                2: begin write_reg(REG_ACK_EVERY, 10'd1023); write_reg(REG_LOSS_ENABLED, 1'b1); end
                3: write_reg(REG_ACK_EVERY, 10'($urandom_range(0, 1000)));
                4: write_reg(REG_ACK_EVERY, 10'd2);
                default: begin write_reg(REG_ACK_EVERY, 10'd1); no_gaps = 1'b1; end
            endcase
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                k = $urandom_range(0, 23);
                it.client_addr   = ($urandom_range(0, 19) == 0) ? $urandom : pool_addr[k];
                it.client_port   = pool_port[k];
                it.mode          = ($urandom_range(0, 2) != 0) ? 16'h0 : 16'($urandom);
                burst            = $urandom_range(0, 15);
                it.seq_num       = (burst == 0) ? SEQ_END :
                                   (burst == 1) ? $urandom : 32'($urandom_range(0, 300));
                it.received_size = 16'($urandom);
                it.header_size   = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                              : it.received_size;
                it.drop_draw     = 1'($urandom);
                send_item(it, 1'b0, '0);
            end
            // After phase 2, hold off the sender until all outstanding results arrive
            if (ph == 2) while (expected_results.size() != 0) @(posedge i_clk);
        end

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SESSIONS + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
